### hw/rtl/mesh_neighbor_table_checker_top_macros.svh
// Assertion macros for the mesh neighbor table checker
`ifndef MESH_NEIGHBOR_TABLE_CHECKER_TOP_MACROS_SVH
`define MESH_NEIGHBOR_TABLE_CHECKER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MNTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MNTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mntc_pkg.sv
// Shared types and constants of the mesh neighbor table checker
package mntc_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CHECK  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned SIDX_W  = 14;
  localparam int unsigned SLOT_W  = 2;

  localparam logic [SLOT_W-1:0] NO_SLOT   = 2'd3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = 2'd2;

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic nb_we;
    logic bs_we;
  } tbl_ctrl_t;

endpackage

### hw/rtl/mntc_tables.sv
// Neighbor table and back-slot table memories, registered reads
module mntc_tables #(
  parameter int unsigned Depth = 12288,
  parameter int unsigned AddrW = 14
) (
  input  logic                        clk_i,
  input  mntc_pkg::tbl_ctrl_t         ctrl_i,
  input  logic [AddrW-1:0]            nb_waddr_i,
  input  logic [mntc_pkg::ENTRY_W-1:0] nb_wdata_i,
  input  logic [AddrW-1:0]            nb_raddr_i,
  output logic [mntc_pkg::ENTRY_W-1:0] nb_rdata_o,
  input  logic [AddrW-1:0]            bs_waddr_i,
  input  logic [mntc_pkg::SLOT_W-1:0] bs_wdata_i,
  input  logic [AddrW-1:0]            bs_raddr_i,
  output logic [mntc_pkg::SLOT_W-1:0] bs_rdata_o
);
  import mntc_pkg::*;

  logic [ENTRY_W-1:0] nb_mem [Depth];
  logic [SLOT_W-1:0]  bs_mem [Depth];
  logic [ENTRY_W-1:0] nb_rdata_q;
  logic [SLOT_W-1:0]  bs_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.nb_we) begin
      nb_mem[nb_waddr_i] <= nb_wdata_i;
    end
    nb_rdata_q <= nb_mem[nb_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.bs_we) begin
      bs_mem[bs_waddr_i] <= bs_wdata_i;
    end
    bs_rdata_q <= bs_mem[bs_raddr_i];
  end

  assign nb_rdata_o = nb_rdata_q;
  assign bs_rdata_o = bs_rdata_q;

endmodule

### hw/rtl/mesh_neighbor_table_checker_top.sv
// Mesh neighbor table checker: command decode, check walk sequencer, result registers
//
//   channel  handshake       payload                                                    dir
//   command  start, busy     opcode_i, neighbor_entry_i, triangle_count_i, slot_index_i  in
//   result   result_valid_o  result_kind_o, flag outputs, reciprocal_slot_o             out
//
// Append and clear complete on acceptance and give no item; a read gives its item through ST_RD.
// A failed check answers in the next cycle. A passing check walks all 3*count entries over the
// single read port of the neighbor memory: request and evaluate states per entry, the same per
// back-link probe (up to three), a triangle-end state per triangle, plus a done state to report.
// Reset clears all control state; back-slot entries at or above the last passing fill
// read as no slot, so no clearing pass runs. The receiver cannot stall.
module mesh_neighbor_table_checker_top #(
  parameter int unsigned MAX_TRIANGLES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode_i,
  input  logic signed [mntc_pkg::ENTRY_W-1:0] neighbor_entry_i,
  input  logic [mntc_pkg::COUNT_W-1:0]        triangle_count_i,
  input  logic [mntc_pkg::SIDX_W-1:0]         slot_index_i,
  output logic                                result_valid_o,
  output logic                                result_kind_o,
  output logic                                range_error_o,
  output logic                                open_slot_o,
  output logic                                self_link_o,
  output logic                                asymmetry_o,
  output logic                                duplicate_o,
  output logic [mntc_pkg::SLOT_W-1:0]         reciprocal_slot_o
);
  import mntc_pkg::*;
  `include "mesh_neighbor_table_checker_top_macros.svh"

  localparam int unsigned DEPTH = 3 * MAX_TRIANGLES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (AW + 1 > 16) ? AW + 1 : 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_E_REQ,
    ST_E_EVAL,
    ST_B_REQ,
    ST_B_EVAL,
    ST_TRI_END,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [LW-1:0]        lc_q;
  logic                 ovf_q;
  logic [LW-1:0]        lim_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   tri_q;
  logic [AW-1:0]        idx_q;
  logic [1:0]           s_q;
  logic [1:0]           o_q;
  logic [AW-1:0]        nbase_q;
  logic [ENTRY_W-1:0]   nb_q [3];
  logic                 in_range_q;
  logic                 valid_q;
  logic                 kind_q;
  logic                 rng_q;
  logic                 open_q;
  logic                 self_q;
  logic                 asym_q;
  logic                 dup_q;
  logic [SLOT_W-1:0]    slot_q;

  opcode_e              op;
  logic                 acc;
  tbl_ctrl_t            ctrl;
  logic [AW-1:0]        nb_raddr;
  logic [ENTRY_W-1:0]   nb_rdata;
  logic [SLOT_W-1:0]    bs_wdata;
  logic [SLOT_W-1:0]    bs_rdata;
  logic [CW-1:0]        cnt_w;
  logic [CW-1:0]        cnt3;
  logic                 chk_err;
  logic                 lc_full;
  logic [AW-1:0]        n_a;
  logic [AW-1:0]        n3;
  logic                 e_open;
  logic                 e_rng;
  logic                 e_self;
  logic                 b_hit;
  logic                 dup_tri;
  logic [COUNT_W-1:0]   tri_nx;

  assign op   = opcode_e'(opcode_i);
  assign busy = (state_q != ST_IDLE);
  assign acc  = start && (state_q == ST_IDLE);

  assign cnt_w   = CW'(triangle_count_i);
  assign cnt3    = (cnt_w << 1) + cnt_w;
  assign lc_full = (lc_q >= LW'(DEPTH));
  assign chk_err = ovf_q || (cnt_w > CW'(MAX_TRIANGLES)) || (cnt3 != CW'(lc_q));

  assign n_a    = AW'(nb_rdata[ENTRY_W-2:0]);
  assign n3     = (n_a << 1) + n_a;
  assign e_open = nb_rdata[ENTRY_W-1];
  assign e_rng  = !e_open && (nb_rdata >= ENTRY_W'(count_q));
  assign e_self = !e_open && !e_rng && (nb_rdata == ENTRY_W'(tri_q));
  assign b_hit  = (nb_rdata == ENTRY_W'(tri_q));
  assign tri_nx = tri_q + COUNT_W'(1);

  assign dup_tri = (!nb_q[0][ENTRY_W-1] && (nb_q[0] == nb_q[1]))
                || (!nb_q[1][ENTRY_W-1] && (nb_q[1] == nb_q[2]))
                || (!nb_q[2][ENTRY_W-1] && (nb_q[2] == nb_q[0]));

  always_comb begin
    ctrl.nb_we = acc && (op == OP_APPEND) && !lc_full;
    ctrl.bs_we = 1'b0;
    bs_wdata   = NO_SLOT;
    nb_raddr   = idx_q;
    unique case (state_q)
      ST_E_EVAL: begin
        ctrl.bs_we = e_open || e_rng || e_self;
      end
      ST_B_REQ: begin
        nb_raddr = nbase_q + AW'(o_q);
      end
      ST_B_EVAL: begin
        ctrl.bs_we = b_hit || (o_q == LAST_SLOT);
        bs_wdata   = b_hit ? o_q : NO_SLOT;
      end
      default: begin
      end
    endcase
  end

  mntc_tables #(
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_tables (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .nb_waddr_i (lc_q[AW-1:0]),
    .nb_wdata_i (neighbor_entry_i),
    .nb_raddr_i (nb_raddr),
    .nb_rdata_o (nb_rdata),
    .bs_waddr_i (idx_q),
    .bs_wdata_i (bs_wdata),
    .bs_raddr_i (AW'(slot_index_i)),
    .bs_rdata_o (bs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lc_q       <= '0;
      ovf_q      <= 1'b0;
      lim_q      <= '0;
      count_q    <= '0;
      tri_q      <= '0;
      idx_q      <= '0;
      s_q        <= '0;
      o_q        <= '0;
      nbase_q    <= '0;
      nb_q[0]    <= '0;
      nb_q[1]    <= '0;
      nb_q[2]    <= '0;
      in_range_q <= 1'b0;
      valid_q    <= 1'b0;
      kind_q     <= KIND_CHECK;
      rng_q      <= 1'b0;
      open_q     <= 1'b0;
      self_q     <= 1'b0;
      asym_q     <= 1'b0;
      dup_q      <= 1'b0;
      slot_q     <= NO_SLOT;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            unique case (op)
              OP_APPEND: begin
                if (lc_full) begin
                  ovf_q <= 1'b1;
                end else begin
                  lc_q <= lc_q + LW'(1);
                end
              end
              OP_CLEAR: begin
                lc_q  <= '0;
                ovf_q <= 1'b0;
              end
              OP_READ: begin
                in_range_q <= (CW'(slot_index_i) < CW'(lim_q));
                state_q    <= ST_RD;
              end
              OP_CHECK: begin
                kind_q  <= KIND_CHECK;
                slot_q  <= NO_SLOT;
                open_q  <= 1'b0;
                self_q  <= 1'b0;
                asym_q  <= 1'b0;
                dup_q   <= 1'b0;
                count_q <= triangle_count_i;
                tri_q   <= '0;
                idx_q   <= '0;
                s_q     <= '0;
                if (chk_err) begin
                  rng_q   <= 1'b1;
                  valid_q <= 1'b1;
                end else begin
                  rng_q   <= 1'b0;
                  lim_q   <= lc_q;
                  state_q <= (triangle_count_i == '0) ? ST_DONE : ST_E_REQ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD: begin
          valid_q <= 1'b1;
          kind_q  <= KIND_READ;
          rng_q   <= 1'b0;
          open_q  <= 1'b0;
          self_q  <= 1'b0;
          asym_q  <= 1'b0;
          dup_q   <= 1'b0;
          slot_q  <= in_range_q ? bs_rdata : NO_SLOT;
          state_q <= ST_IDLE;
        end
        ST_E_REQ: begin
          state_q <= ST_E_EVAL;
        end
        ST_E_EVAL: begin
          nb_q[s_q] <= nb_rdata;
          if (e_open || e_rng || e_self) begin
            open_q <= open_q | e_open;
            rng_q  <= rng_q | e_rng;
            self_q <= self_q | e_self;
            idx_q  <= idx_q + AW'(1);
            if (s_q == LAST_SLOT) begin
              s_q     <= '0;
              state_q <= ST_TRI_END;
            end else begin
              s_q     <= s_q + 2'd1;
              state_q <= ST_E_REQ;
            end
          end else begin
            nbase_q <= n3;
            o_q     <= '0;
            state_q <= ST_B_REQ;
          end
        end
        ST_B_REQ: begin
          state_q <= ST_B_EVAL;
        end
        ST_B_EVAL: begin
          if (b_hit || (o_q == LAST_SLOT)) begin
            asym_q <= asym_q | !b_hit;
            idx_q  <= idx_q + AW'(1);
            if (s_q == LAST_SLOT) begin
              s_q     <= '0;
              state_q <= ST_TRI_END;
            end else begin
              s_q     <= s_q + 2'd1;
              state_q <= ST_E_REQ;
            end
          end else begin
            o_q     <= o_q + 2'd1;
            state_q <= ST_B_REQ;
          end
        end
        ST_TRI_END: begin
          dup_q   <= dup_q | dup_tri;
          tri_q   <= tri_nx;
          state_q <= (tri_nx == count_q) ? ST_DONE : ST_E_REQ;
        end
        ST_DONE: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o    = valid_q;
  assign result_kind_o     = kind_q;
  assign range_error_o     = rng_q;
  assign open_slot_o       = open_q;
  assign self_link_o       = self_q;
  assign asymmetry_o       = asym_q;
  assign duplicate_o       = dup_q;
  assign reciprocal_slot_o = slot_q;

  `MNTC_ASSERT_NEXT(a_ovf_check, acc && (op == OP_CHECK) && ovf_q, result_valid_o && range_error_o && !open_slot_o && (result_kind_o == KIND_CHECK), "overflowed table must fail check")
  `MNTC_ASSERT_NEXT(a_read_out, state_q == ST_RD, result_valid_o && (result_kind_o == KIND_READ), "read must deliver its item")
  `MNTC_ASSERT_SAME(a_read_clean, result_valid_o && (result_kind_o == KIND_READ), !(range_error_o || open_slot_o || self_link_o || asymmetry_o || duplicate_o), "read item carries flags")
  `MNTC_ASSERT_NEXT(a_silent_ops, acc && ((op == OP_APPEND) || (op == OP_CLEAR)), !result_valid_o, "append or clear produced an item")
  `MNTC_ASSERT_SAME(a_lc_bound, 1'b1, lc_q <= LW'(DEPTH), "loaded count beyond capacity")

endmodule
